// ----- src/srmka_pkg.sv -----
package srmka_pkg;

   localparam int ROW_W = 32;
   localparam int COL_W = 32;
   localparam int VAL_W = 48;
   localparam int CSR_W = 32;
   localparam int CSR_IDX_W = 1;
   localparam int CLEN_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_LENGTH = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DROP_MARKER = 1'd1;

   localparam logic [CLEN_W-1:0] CHUNK_LENGTH_RESET = 5'd8;
   localparam logic [COL_W-1:0] DROP_MARKER_RESET = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_ISSUE,
      ST_TAKE,
      ST_PICK
   } state_type;

   typedef struct packed {
      logic load;
      logic start;
      logic issue;
      logic skip;
      logic take;
      logic consume;
      logic emit;
      logic last;
   } cmd_type;

   typedef struct packed {
      logic req_fire;
      logic group_end;
      logic has_entry;
      logic rd_drop;
      logic best_found;
      logic best_match;
      logic pend_valid;
      logic out_busy;
   } status_type;

endpackage

// ----- src/srmka_if.sv -----
interface srmka_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] entry_row;
   logic [31:0] entry_col;
   logic signed [47:0] entry_val;
   logic        group_end;

   modport source (output valid, entry_row, entry_col, entry_val, group_end, input ready);
   modport sink (input valid, entry_row, entry_col, entry_val, group_end, output ready);
endinterface

interface srmka_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] out_row;
   logic [31:0] out_col;
   logic signed [47:0] out_val;
   logic        out_last;
   logic        truncated;

   modport source (output valid, out_row, out_col, out_val, out_last, truncated, input ready);
   modport sink (input valid, out_row, out_col, out_val, out_last, truncated, output ready);
endinterface

// ----- src/srmka_ctrl.sv -----
module srmka_ctrl #(
   parameter int MAX_CHUNKS = 4,
   parameter int SEL_W = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  srmka_pkg::status_type status,
   input  logic [SEL_W-1:0]     best_sel,
   output srmka_pkg::cmd_type    cmd,
   output logic [SEL_W-1:0]     sel,
   output logic                 req_ready
);
   import srmka_pkg::*;

   localparam logic [SEL_W-1:0] LAST_SEL = SEL_W'(MAX_CHUNKS - 1);

   state_type state_ff, state_in;
   logic [SEL_W-1:0] sel_ff, sel_in;
   logic sweep_ff, sweep_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff <= '0;
         sweep_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff <= sel_in;
         sweep_ff <= sweep_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      sel_in = sel_ff;
      sweep_in = sweep_ff;
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (status.req_fire) begin
               cmd.load = 1'b1;
               if (status.group_end) begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            cmd.start = 1'b1;
            sel_in = '0;
            sweep_in = 1'b1;
            state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            if (status.has_entry) begin
               state_in = ST_TAKE;
            end else if (sweep_ff && sel_ff != LAST_SEL) begin
               sel_in = sel_ff + 1'b1;
            end else begin
               sweep_in = 1'b0;
               state_in = ST_PICK;
            end
         end
         ST_TAKE: begin
            if (status.rd_drop) begin
               cmd.skip = 1'b1;
               state_in = ST_ISSUE;
            end else begin
               cmd.take = 1'b1;
               if (sweep_ff && sel_ff != LAST_SEL) begin
                  sel_in = sel_ff + 1'b1;
                  state_in = ST_ISSUE;
               end else begin
                  sweep_in = 1'b0;
                  state_in = ST_PICK;
               end
            end
         end
         ST_PICK: begin
            if (status.best_found) begin
               if (status.best_match) begin
                  cmd.consume = 1'b1;
                  sel_in = best_sel;
                  state_in = ST_ISSUE;
               end else if (!(status.pend_valid && status.out_busy)) begin
                  cmd.emit = status.pend_valid;
                  cmd.consume = 1'b1;
                  sel_in = best_sel;
                  state_in = ST_ISSUE;
               end
            end else if (status.pend_valid) begin
               if (!status.out_busy) begin
                  cmd.emit = 1'b1;
                  cmd.last = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign sel = sel_ff;

endmodule

// ----- src/srmka_datapath.sv -----
module srmka_datapath #(
   parameter int MAX_CHUNK_LEN = 16,
   parameter int MAX_CHUNKS = 4,
   parameter int SEL_W = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [srmka_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [srmka_pkg::CSR_W-1:0]       csr_wdata,
   input  logic [srmka_pkg::ROW_W-1:0]       in_row,
   input  logic [srmka_pkg::COL_W-1:0]       in_col,
   input  logic signed [srmka_pkg::VAL_W-1:0] in_val,
   input  srmka_pkg::cmd_type                cmd,
   input  logic [SEL_W-1:0]                  sel,
   output srmka_pkg::status_type             status,
   output logic [SEL_W-1:0]                  best_sel,
   input  logic                              rsp_fire,
   output logic                              out_valid,
   output logic [srmka_pkg::ROW_W-1:0]       out_row,
   output logic [srmka_pkg::COL_W-1:0]       out_col,
   output logic signed [srmka_pkg::VAL_W-1:0] out_val,
   output logic                              out_last,
   output logic                              out_trunc
);
   import srmka_pkg::*;

   localparam int DEPTH = MAX_CHUNKS * MAX_CHUNK_LEN;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [ROW_W-1:0] mem_row [DEPTH];
   logic [COL_W-1:0] mem_col [DEPTH];
   logic signed [VAL_W-1:0] mem_val [DEPTH];

   logic [CLEN_W-1:0] clen_ff;
   logic [COL_W-1:0] marker_ff;
   logic [CNT_W-1:0] fill_ff;
   logic overflow_ff;
   logic trunc_ff;

   logic [CNT_W-1:0] ptr_ff [MAX_CHUNKS];
   logic [CNT_W-1:0] end_ff [MAX_CHUNKS];
   logic hv_ff [MAX_CHUNKS];
   logic [ROW_W-1:0] hrow_ff [MAX_CHUNKS];
   logic [COL_W-1:0] hcol_ff [MAX_CHUNKS];
   logic signed [VAL_W-1:0] hval_ff [MAX_CHUNKS];

   logic [ROW_W-1:0] rd_row_ff;
   logic [COL_W-1:0] rd_col_ff;
   logic signed [VAL_W-1:0] rd_val_ff;

   logic pend_valid_ff;
   logic [ROW_W-1:0] pend_row_ff;
   logic [COL_W-1:0] pend_col_ff;
   logic signed [VAL_W-1:0] pend_val_ff;

   logic out_valid_ff;
   logic [ROW_W-1:0] out_row_ff;
   logic [COL_W-1:0] out_col_ff;
   logic signed [VAL_W-1:0] out_val_ff;
   logic out_last_ff;
   logic out_trunc_ff;

   logic [CNT_W-1:0] len;
   logic [CNT_W-1:0] cap;
   logic [CNT_W-1:0] span;
   logic space;
   logic [ADDR_W-1:0] rd_addr;
   logic found;
   logic [SEL_W-1:0] best;
   logic [COL_W-1:0] best_col;
   logic signed [VAL_W:0] sum;
   logic signed [VAL_W-1:0] sat_sum;

   always_comb begin
      if (clen_ff == '0) begin
         len = CNT_W'(1);
      end else if (int'(clen_ff) > MAX_CHUNK_LEN) begin
         len = CNT_W'(MAX_CHUNK_LEN);
      end else begin
         len = CNT_W'(clen_ff);
      end
      cap = CNT_W'(MAX_CHUNKS * int'(len));
      span = (fill_ff > cap) ? cap : fill_ff;
      space = fill_ff < cap;
      rd_addr = ptr_ff[sel][ADDR_W-1:0];
   end

   always_comb begin
      found = 1'b0;
      best = '0;
      best_col = marker_ff;
      for (int c = 0; c < MAX_CHUNKS; c++) begin
         if (hv_ff[c] && hcol_ff[c] < best_col) begin
            found = 1'b1;
            best = SEL_W'(c);
            best_col = hcol_ff[c];
         end
      end
      sum = {pend_val_ff[VAL_W-1], pend_val_ff} + {hval_ff[best][VAL_W-1], hval_ff[best]};
      if (sum[VAL_W] != sum[VAL_W-1]) begin
         sat_sum = {sum[VAL_W], {(VAL_W - 1){~sum[VAL_W]}}};
      end else begin
         sat_sum = sum[VAL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && space) begin
         mem_row[fill_ff[ADDR_W-1:0]] <= in_row;
         mem_col[fill_ff[ADDR_W-1:0]] <= in_col;
         mem_val[fill_ff[ADDR_W-1:0]] <= in_val;
      end
      if (cmd.issue) begin
         rd_row_ff <= mem_row[rd_addr];
         rd_col_ff <= mem_col[rd_addr];
         rd_val_ff <= mem_val[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clen_ff <= CHUNK_LENGTH_RESET;
         marker_ff <= DROP_MARKER_RESET;
         fill_ff <= '0;
         overflow_ff <= 1'b0;
         trunc_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int c = 0; c < MAX_CHUNKS; c++) begin
            hv_ff[c] <= 1'b0;
            ptr_ff[c] <= '0;
            end_ff[c] <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_CHUNK_LENGTH: clen_ff <= csr_wdata[CLEN_W-1:0];
               CSR_DROP_MARKER: marker_ff <= csr_wdata[COL_W-1:0];
               default: ;
            endcase
         end
         if (cmd.load) begin
            if (space) begin
               fill_ff <= fill_ff + 1'b1;
            end else begin
               overflow_ff <= 1'b1;
            end
         end
         if (cmd.start) begin
            trunc_ff <= overflow_ff || (fill_ff > cap);
            overflow_ff <= 1'b0;
            fill_ff <= '0;
            pend_valid_ff <= 1'b0;
            for (int c = 0; c < MAX_CHUNKS; c++) begin
               hv_ff[c] <= 1'b0;
               ptr_ff[c] <= CNT_W'(c * int'(len));
               if (CNT_W'(c * int'(len)) + len > span) begin
                  end_ff[c] <= span;
               end else begin
                  end_ff[c] <= CNT_W'(c * int'(len)) + len;
               end
            end
         end
         if (cmd.skip) begin
            ptr_ff[sel] <= ptr_ff[sel] + 1'b1;
         end
         if (cmd.take) begin
            ptr_ff[sel] <= ptr_ff[sel] + 1'b1;
            hv_ff[sel] <= 1'b1;
            hrow_ff[sel] <= rd_row_ff;
            hcol_ff[sel] <= rd_col_ff;
            hval_ff[sel] <= rd_val_ff;
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
            out_row_ff <= pend_row_ff;
            out_col_ff <= pend_col_ff;
            out_val_ff <= pend_val_ff;
            out_last_ff <= cmd.last;
            out_trunc_ff <= trunc_ff;
            if (cmd.last) begin
               pend_valid_ff <= 1'b0;
            end
         end else if (rsp_fire) begin
            out_valid_ff <= 1'b0;
         end
         if (cmd.consume) begin
            hv_ff[best] <= 1'b0;
            if (pend_valid_ff && best_col == pend_col_ff) begin
               pend_val_ff <= sat_sum;
            end else begin
               pend_valid_ff <= 1'b1;
               pend_row_ff <= hrow_ff[best];
               pend_col_ff <= best_col;
               pend_val_ff <= hval_ff[best];
            end
         end
      end
   end

   always_comb begin
      status.req_fire = 1'b0;
      status.group_end = 1'b0;
      status.has_entry = ptr_ff[sel] < end_ff[sel];
      status.rd_drop = rd_row_ff == marker_ff;
      status.best_found = found;
      status.best_match = pend_valid_ff && best_col == pend_col_ff;
      status.pend_valid = pend_valid_ff;
      status.out_busy = out_valid_ff;
   end

   assign best_sel = best;
   assign out_valid = out_valid_ff;
   assign out_row = out_row_ff;
   assign out_col = out_col_ff;
   assign out_val = out_val_ff;
   assign out_last = out_last_ff;
   assign out_trunc = out_trunc_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !out_valid_ff)
      else $error("result overwritten before it was taken");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH))
      else $error("fill count beyond store depth");
   a_take_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> $past(cmd.issue) && ptr_ff[sel] < end_ff[sel])
      else $error("head taken without a valid read");

endmodule

// ----- src/sparse_row_kway_merge_accumulate.sv -----
// Channel   Dir  Payload                                         Handshake
// req       in   entry_row, entry_col, entry_val, group_end      req.valid / req.ready
// rsp       out  out_row, out_col, out_val, out_last, truncated  rsp.valid / rsp.ready
// csr       in   csr_index, csr_wdata                            csr_we
//
// Loading takes one request per cycle while the merge engine is idle.
// After the group end the engine passes through a setup state, then fetches the head of each
// nonempty chunk with a memory read and a head load (an empty chunk needs only the read), then
// handles each stored entry by pick, read and head load; a dropped entry by read and skip.
// The single read port of the entry store sets these steps.
// Reset is synchronous and clears all control state; the store needs no clearing.
// A result waiting on rsp.ready stalls the merge only when the next result must be emitted.
module sparse_row_kway_merge_accumulate #(
   parameter int MAX_CHUNK_LEN = 16,
   parameter int MAX_CHUNKS = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   srmka_req_if.sink                       req,
   srmka_rsp_if.source                     rsp,
   input  logic                            csr_we,
   input  logic [srmka_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [srmka_pkg::CSR_W-1:0]     csr_wdata
);
   import srmka_pkg::*;

   localparam int SEL_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

   cmd_type cmd;
   status_type dp_status;
   status_type status;
   logic [SEL_W-1:0] sel;
   logic [SEL_W-1:0] best_sel;
   logic req_ready;

   always_comb begin
      status = dp_status;
      status.req_fire = req.valid && req_ready;
      status.group_end = req.group_end;
   end

   assign req.ready = req_ready;

   srmka_ctrl #(
      .MAX_CHUNKS(MAX_CHUNKS),
      .SEL_W(SEL_W)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .status(status),
      .best_sel(best_sel),
      .cmd(cmd),
      .sel(sel),
      .req_ready(req_ready)
   );

   srmka_datapath #(
      .MAX_CHUNK_LEN(MAX_CHUNK_LEN),
      .MAX_CHUNKS(MAX_CHUNKS),
      .SEL_W(SEL_W)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .in_row(req.entry_row),
      .in_col(req.entry_col),
      .in_val(req.entry_val),
      .cmd(cmd),
      .sel(sel),
      .status(dp_status),
      .best_sel(best_sel),
      .rsp_fire(rsp.valid && rsp.ready),
      .out_valid(rsp.valid),
      .out_row(rsp.out_row),
      .out_col(rsp.out_col),
      .out_val(rsp.out_val),
      .out_last(rsp.out_last),
      .out_trunc(rsp.truncated)
   );

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
   import srmka_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHUNK_CAP = 16;
   localparam int CHUNK_SLOTS = 4;
   localparam int STORE_SLOTS = CHUNK_CAP * CHUNK_SLOTS;
   localparam int SETTLE_CYCLES = 400;
   localparam logic signed [47:0] VAL_HI = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] VAL_LO = 48'sh8000_0000_0000;

   typedef struct {
      logic [31:0]        row;
      logic [31:0]        col;
      logic signed [47:0] val;
      logic               grp_end;
   } entry_type;

   typedef struct {
      logic [31:0]        row;
      logic [31:0]        col;
      logic signed [47:0] val;
      logic               last;
      logic               trunc;
   } merged_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   srmka_req_if req_ch();
   srmka_rsp_if rsp_ch();

   sparse_row_kway_merge_accumulate DUT (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   entry_type entry_backlog[$];
   merged_type pending_results[$];
   int errors = 0;
   int sent_items = 0;
   int idle_mode = 0;
   int hold_asks = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int gap_left = 0;

   logic [4:0]  cfg_len = CHUNK_LENGTH_RESET;
   logic [31:0] cfg_marker = DROP_MARKER_RESET;
   logic [31:0] st_row[STORE_SLOTS];
   logic [31:0] st_col[STORE_SLOTS];
   logic signed [47:0] st_val[STORE_SLOTS];
   int fill = 0;
   bit overflow = 0;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (idle_mode == 0) return 0;
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [47:0] sat_sum(logic signed [47:0] a, logic signed [47:0] b);
      logic signed [48:0] s;
      s = {a[47], a} + {b[47], b};
      if (s > $signed({VAL_HI[47], VAL_HI})) return VAL_HI;
      if (s < $signed({VAL_LO[47], VAL_LO})) return VAL_LO;
      return s[47:0];
   endfunction

   task automatic absorb_entry(entry_type e);
      int len, cap, span, nch, best, best_idx, base, lim;
      int heads[CHUNK_SLOTS];
      logic [31:0] best_col, last_col;
      merged_type group_out[$];
      merged_type m;
      bit trunc;
      len = (cfg_len == 0) ? 1 : (cfg_len > CHUNK_CAP) ? CHUNK_CAP : int'(cfg_len);
      cap = CHUNK_SLOTS * len;
      if (fill < cap) begin
         st_row[fill] = e.row;
         st_col[fill] = e.col;
         st_val[fill] = e.val;
         fill++;
      end else begin
         overflow = 1;
      end
      if (!e.grp_end) return;
      span = fill;
      if (span > cap) begin
         span = cap;
         overflow = 1;
      end
      nch = (span + len - 1) / len;
      trunc = overflow;
      last_col = 0;
      foreach (heads[c]) heads[c] = 0;
      while (1) begin
         best = -1;
         best_col = cfg_marker;
         best_idx = 0;
         for (int c = 0; c < nch && c < CHUNK_SLOTS; c++) begin
            base = c * len;
            lim = (base + len > span) ? span : base + len;
            while (base + heads[c] < lim && st_row[base + heads[c]] == cfg_marker) heads[c]++;
            if (base + heads[c] < lim && st_col[base + heads[c]] < best_col) begin
               best_col = st_col[base + heads[c]];
               best = c;
               best_idx = base + heads[c];
            end
         end
         if (best < 0) break;
         heads[best]++;
         if (group_out.size() > 0 && best_col == last_col) begin
            group_out[$].val = sat_sum(group_out[$].val, st_val[best_idx]);
         end else begin
            m.row = st_row[best_idx];
            m.col = best_col;
            m.val = st_val[best_idx];
            m.last = 1'b0;
            m.trunc = trunc;
            group_out.push_back(m);
            last_col = best_col;
         end
      end
      if (group_out.size() > 0) group_out[$].last = 1'b1;
      foreach (group_out[i]) pending_results.push_back(group_out[i]);
      fill = 0;
      overflow = 0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            absorb_entry('{req_ch.entry_row, req_ch.entry_col, req_ch.entry_val,
                           req_ch.group_end});
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (entry_backlog.size() > 0) begin
               entry_type e;
               e = entry_backlog.pop_front();
               req_ch.entry_row <= e.row;
               req_ch.entry_col <= e.col;
               req_ch.entry_val <= e.val;
               req_ch.group_end <= e.grp_end;
               req_ch.valid <= 1'b1;
               gap_left = pick_gap();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_seen != hold_asks) begin
         hold_seen = hold_asks;
         hold_left = 300;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= (pick_gap() == 0);
      end
   end

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch on %s: got %h, expected %h", what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            report("unexpected result column", 64'(rsp_ch.out_col), 64'd0);
         end else begin
            merged_type w;
            w = pending_results.pop_front();
            if (rsp_ch.out_row !== w.row) report("out_row", 64'(rsp_ch.out_row), 64'(w.row));
            if (rsp_ch.out_col !== w.col) report("out_col", 64'(rsp_ch.out_col), 64'(w.col));
            if (rsp_ch.out_val !== w.val) report("out_val", 64'(rsp_ch.out_val), 64'(w.val));
            if (rsp_ch.out_last !== w.last)
               report("out_last", 64'(rsp_ch.out_last), 64'(w.last));
            if (rsp_ch.truncated !== w.trunc)
               report("truncated", 64'(rsp_ch.truncated), 64'(w.trunc));
         end
      end
   end

   task automatic add(logic [31:0] row, logic [31:0] col, logic signed [47:0] val, logic ge);
      entry_backlog.push_back('{row, col, val, ge});
      sent_items++;
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_CHUNK_LENGTH) cfg_len = data[4:0];
      else cfg_marker = data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (entry_backlog.size() > 0 || req_ch.valid || pending_results.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [47:0] rand_val();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return VAL_HI - 48'($urandom_range(0, 3));
      if (r == 1) return VAL_LO + 48'($urandom_range(0, 3));
      if (r < 5) return 48'($signed($urandom_range(0, 2000)) - 1000);
      return {16'($urandom), 32'($urandom)};
   endfunction

   task automatic build_group();
      int len, nch, cnt, wide;
      logic [31:0] cols[$];
      logic [31:0] row;
      bit noisy;
      len = (cfg_len == 0) ? 1 : (cfg_len > CHUNK_CAP) ? CHUNK_CAP : int'(cfg_len);
      nch = ($urandom_range(0, 9) == 0) ? 5 : $urandom_range(1, 4);
      if (len > 8 && $urandom_range(0, 3) != 0) nch = 1;
      noisy = ($urandom_range(0, 9) == 0);
      wide = $urandom_range(0, 2);
      for (int c = 0; c < nch; c++) begin
         cnt = (c == nch - 1) ? $urandom_range(1, len) : len;
         cols.delete();
         for (int k = 0; k < cnt; k++) begin
            if (wide == 0) cols.push_back($urandom);
            else if (wide == 1) cols.push_back($urandom_range(0, 20));
            else cols.push_back(cfg_marker - 32'($urandom_range(0, 12)));
         end
         if (!noisy) cols.sort();
         foreach (cols[k]) begin
            row = ($urandom_range(0, 6) == 0) ? cfg_marker : $urandom;
            add(row, cols[k], rand_val(),
                (c == nch - 1 && k == cols.size() - 1) ? 1'b1 : 1'b0);
         end
      end
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.entry_row = '0;
      req_ch.entry_col = '0;
      req_ch.entry_val = '0;
      req_ch.group_end = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_CHUNK_LENGTH;
      csr_wdata = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      add(32'd0, 32'd0, VAL_HI, 1'b1);
      add(32'hFFFF_FFFE, 32'hFFFF_FFFE, VAL_LO, 1'b1);
      add(32'd7, 32'd9, VAL_HI, 1'b0);
      add(32'd8, 32'd9, VAL_HI, 1'b1);
      add(32'd7, 32'd4, VAL_LO, 1'b0);
      add(32'd8, 32'd4, -48'sd1, 1'b1);
      add(32'hFFFF_FFFF, 32'd1, 48'sd5, 1'b0);
      add(32'd3, 32'hFFFF_FFFF, 48'sd6, 1'b1);
      drain();

      write_reg(CSR_CHUNK_LENGTH, 32'd1);
      add(32'd1, 32'd5, 48'sd1, 1'b0);
      add(32'd2, 32'd3, 48'sd2, 1'b0);
      add(32'd3, 32'd5, 48'sd3, 1'b0);
      add(32'd4, 32'd3, 48'sd4, 1'b0);
      add(32'd5, 32'd1, 48'sd5, 1'b1);
      drain();

      write_reg(CSR_CHUNK_LENGTH, 32'd0);
      write_reg(CSR_DROP_MARKER, 32'd50);
      add(32'd50, 32'd1, 48'sd1, 1'b0);
      add(32'd2, 32'd60, 48'sd1, 1'b1);
      drain();

      write_reg(CSR_CHUNK_LENGTH, 32'd31);
      add(32'd1, 32'd9, 48'sd1, 1'b0);
      add(32'd1, 32'd2, 48'sd2, 1'b1);
      drain();
      write_reg(CSR_CHUNK_LENGTH, 32'd4);
      for (int k = 0; k < 12; k++) add(32'(k), 32'(k % 4), 48'(k), 1'b0);
      drain();
      write_reg(CSR_CHUNK_LENGTH, 32'd2);
      add(32'd99, 32'd0, 48'sd1, 1'b1);
      drain();

      for (int phase = 0; sent_items < 230; phase++) begin
         case (phase % 5)
            0: begin
               write_reg(CSR_CHUNK_LENGTH, 32'd16);
               write_reg(CSR_DROP_MARKER, 32'hFFFF_FFFF);
            end
            1: write_reg(CSR_CHUNK_LENGTH, 32'd1);
            2: begin
               write_reg(CSR_CHUNK_LENGTH, 32'($urandom_range(0, 31)));
               write_reg(CSR_DROP_MARKER, $urandom);
            end
            3: write_reg(CSR_DROP_MARKER, 32'd0);
            default: begin
               write_reg(CSR_CHUNK_LENGTH, 32'($urandom_range(2, 6)));
               write_reg(CSR_DROP_MARKER, 32'($urandom_range(10, 30)));
            end
         endcase
         idle_mode = phase % 3;
         if (phase == 1) hold_asks++;
         for (int g = 0; g < 6; g++) build_group();
         drain();
      end

      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #(20 * 400000);
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
